### rtl/core/spmf_pkg.sv
// Package with the widths, constants, types and helpers of the scan peak matched filter.
`timescale 1ns / 1ps
package spmf_pkg;

    localparam int HIST_DEPTH = 1024;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int POS_W      = 16;
    localparam int RATIO_W    = 32;
    localparam int FILT_W     = 37;
    localparam int PEAK_W     = 35;
    localparam int TAP_W      = 10;
    localparam int NUM_TAPS   = 5;
    localparam int ENTRY_W    = POS_W + RATIO_W;
    localparam int OUT_DATA_W = 184;

    localparam logic [POS_W-1:0] K_Q12  = 16'd103;
    localparam logic [POS_W-1:0] K_Q11  = 16'd710;
    localparam logic [POS_W-1:0] K_WING = 16'd156;

    localparam logic REG_PEAK_LOW  = 1'b0;
    localparam logic REG_PEAK_HIGH = 1'b1;

    // Tap slots in the order the sequencer reads them.
    localparam logic [2:0] TAP_Q12C = 3'd0;
    localparam logic [2:0] TAP_Q12L = 3'd1;
    localparam logic [2:0] TAP_Q11R = 3'd2;
    localparam logic [2:0] TAP_Q11C = 3'd3;
    localparam logic [2:0] TAP_Q11L = 3'd4;
    localparam logic [2:0] TAP_DONE = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_ENTER,
        S_TAP,
        S_EVAL,
        S_FIN
    } state_t;

    // Ring slot k entries behind the head.
    function automatic logic [HIST_AW-1:0] slot_back(input logic [HIST_AW-1:0] head,
                                                     input logic [TAP_W-1:0] k);
        logic [HIST_AW:0] diff;
        diff = {1'b0, head} - (HIST_AW + 1)'(k);
        if (diff[HIST_AW])
        begin
            diff = diff + (HIST_AW + 1)'(HIST_DEPTH);
        end
        return diff[HIST_AW-1:0];
    endfunction

endpackage

### rtl/core/spmf_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module spmf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/spmf_div.sv
// Restoring divider, one quotient bit per cycle, for the tap offset computation.
`timescale 1ns / 1ps
module spmf_div
    import spmf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [POS_W-1:0] num,
    input  logic [POS_W-1:0] den,
    output logic             done,
    output logic [TAP_W-1:0] quo
);

    logic [4:0]       cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [POS_W:0]   rem_reg;
    logic [POS_W-1:0] dvd_reg;
    logic [POS_W-1:0] quo_reg;
    logic [POS_W-1:0] den_reg;
    logic [POS_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg[POS_W-1:0], dvd_reg[POS_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            dvd_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= 5'(POS_W);
                run_reg <= 1'b1;
                rem_reg <= '0;
                dvd_reg <= num;
                quo_reg <= '0;
                den_reg <= den;
            end
            else if (run_reg)
            begin
                rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
                quo_reg <= {quo_reg[POS_W-2:0], fits};
                dvd_reg <= {dvd_reg[POS_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    // The numerators keep every quotient below 1024.
    assign quo  = quo_reg[TAP_W-1:0];

endmodule

### rtl/core/scan_peak_matched_filter_core.sv
// Top level: scan point sequencer, history RAM, filter accumulator and result register.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+------------------------------------------
//  s_axis    | s_axis_tvalid/s_axis_tready  | tuser: operation; tdata: position, ratio
//  m_axis    | m_axis_tvalid/m_axis_tready  | tuser: ready_res, scan_over; tdata: results
//  cfg       | cfg_we                       | cfg_addr, cfg_wdata
//
// A recorded point is decoded, written to the history RAM, read at its five taps while the
// previous tap accumulates, evaluated and loaded; the next item waits for the load. Ignored,
// first and drain-without-filter items go from decode to the load; a drain that closes the
// scan passes the enter state first. A scan's second point runs three divisions and enters
// the first point too. Reset clears all control state; the history RAM is not cleared, since
// entries not written in the current scan are masked by the point count. A new item is
// accepted while a result waits; the sequencer stalls only when it must load a second result.
`timescale 1ns / 1ps
module scan_peak_matched_filter_core
    import spmf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [ENTRY_W-1:0]    s_axis_tdata,  // position, ratio
    input  logic [0:0]            s_axis_tuser,  // operation
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // delayed_position, filter_value, delayed_ratio, peak_position, peak_value,
    // scan_rate, first_position, last_position
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [1:0]            m_axis_tuser,  // ready_res, scan_over
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [POS_W-1:0]      cfg_wdata
);

    state_t state_reg, state_next;

    logic [POS_W-1:0]   low_limit_reg, high_limit_reg;
    logic               op_reg;
    logic [POS_W-1:0]   pos_in_reg;
    logic [RATIO_W-1:0] val_in_reg;
    logic [HIST_AW-1:0] head_reg;
    logic [POS_W-1:0]   pc_reg;
    logic [POS_W-1:0]   start_pos_reg, last_pos_reg, steps_reg, aligned_reg, best_pos_reg;
    logic [TAP_W-1:0]   tap_reg [NUM_TAPS];
    logic [FILT_W-1:0]  last_filter_reg, acc_reg;
    logic [PEAK_W-1:0]  best_reg;
    logic               low_seen_reg;
    logic [POS_W-1:0]   low_pos_reg;
    logic [RATIO_W-1:0] latest_reg, dr_reg;
    logic [POS_W-1:0]   e_pos_reg;
    logic [RATIO_W-1:0] e_val_reg;
    logic               pend_reg, ready_flag_reg, over_flag_reg, live_reg;
    logic [2:0]         tap_idx_reg;
    logic [1:0]         div_idx_reg;
    logic [TAP_W-1:0]   q0_reg, q1_reg;
    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [1:0]         out_user_reg;

    logic               accept, mem_we, div_start, out_load;
    logic [HIST_AW-1:0] head_inc, raddr;
    logic [ENTRY_W-1:0] rdata;
    logic               div_done;
    logic [TAP_W-1:0]   div_quo;
    logic [POS_W-1:0]   div_num;
    logic               lower, same, restart, over_hit;
    logic [TAP_W-1:0]   tap_sel;
    logic [2:0]         prev_idx;
    logic [FILT_W-1:0]  r_ext, r_x3;
    logic               peak_take;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign head_inc = (head_reg == HIST_AW'(HIST_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign lower    = (pc_reg != '0) && (pos_in_reg < last_pos_reg);
    assign same     = (pc_reg != '0) && (pos_in_reg == last_pos_reg);
    assign restart  = lower && low_seen_reg && (low_pos_reg < pos_in_reg);
    assign over_hit = (pc_reg != '0) && (aligned_reg == e_pos_reg);
    assign tap_sel  = (tap_idx_reg < TAP_DONE) ? tap_reg[tap_idx_reg] : '0;
    assign raddr    = slot_back(head_reg, tap_sel);
    assign prev_idx = tap_idx_reg - 3'd1;
    assign r_ext    = live_reg ? {{(FILT_W - RATIO_W){1'b0}}, rdata[RATIO_W-1:0]} : '0;
    assign r_x3     = r_ext + {r_ext[FILT_W-2:0], 1'b0};
    assign peak_take = ($signed(acc_reg) > $signed({2'b00, best_reg}))
                       && (aligned_reg >= low_limit_reg) && (aligned_reg < high_limit_reg);

    always_comb
    begin
        case (div_idx_reg)
            2'd0:    div_num = K_Q12;
            2'd1:    div_num = K_Q11;
            default: div_num = K_WING;
        endcase
        div_num = div_num + {1'b0, steps_reg[POS_W-1:1]};
    end

    spmf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (mem_we),
        .waddr (head_inc),
        .wdata ({e_pos_reg, e_val_reg}),
        .raddr (raddr),
        .rdata (rdata)
    );

    spmf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (steps_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (op_reg)
                begin
                    state_next = (pc_reg < 16'd2) ? S_FIN : S_ENTER;
                end
                else if ((lower && !restart) || same)
                begin
                    state_next = S_FIN;
                end
                else if (restart || pc_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else if (pc_reg == 16'd1)
                begin
                    state_next = (pos_in_reg == start_pos_reg) ? S_FIN : S_DIV_GO;
                end
                else
                begin
                    state_next = S_ENTER;
                end
            end
            S_DIV_GO:   state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (div_idx_reg == 2'd2) ? S_ENTER : S_DIV_GO;
                end
            end
            S_ENTER:    state_next = over_hit ? S_FIN : S_TAP;
            S_TAP:
            begin
                if (tap_idx_reg == TAP_DONE)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:     state_next = pend_reg ? S_ENTER : S_FIN;
            S_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            S_IDLE:   s_axis_tready = 1'b1;
            S_DIV_GO: div_start     = 1'b1;
            S_ENTER:  mem_we        = !over_hit;
            S_FIN:    out_load      = !out_valid_reg || m_axis_tready;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            low_limit_reg  <= '0;
            high_limit_reg <= '1;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_addr == REG_PEAK_LOW)
                begin
                    low_limit_reg <= cfg_wdata;
                end
                else
                begin
                    high_limit_reg <= cfg_wdata;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg          <= 1'b0;
            pos_in_reg      <= '0;
            val_in_reg      <= '0;
            head_reg        <= '0;
            pc_reg          <= '0;
            start_pos_reg   <= '0;
            last_pos_reg    <= '0;
            steps_reg       <= '0;
            aligned_reg     <= '0;
            best_pos_reg    <= '0;
            for (int i = 0; i < NUM_TAPS; i++)
            begin
                tap_reg[i] <= '0;
            end
            last_filter_reg <= '0;
            acc_reg         <= '0;
            best_reg        <= '0;
            low_seen_reg    <= 1'b0;
            low_pos_reg     <= '0;
            latest_reg      <= '0;
            dr_reg          <= '0;
            e_pos_reg       <= '0;
            e_val_reg       <= '0;
            pend_reg        <= 1'b0;
            ready_flag_reg  <= 1'b0;
            over_flag_reg   <= 1'b0;
            live_reg        <= 1'b0;
            tap_idx_reg     <= '0;
            div_idx_reg     <= '0;
            q0_reg          <= '0;
            q1_reg          <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg     <= s_axis_tuser[0];
                        pos_in_reg <= s_axis_tdata[POS_W-1:0];
                        val_in_reg <= s_axis_tdata[ENTRY_W-1:POS_W];
                    end
                    ready_flag_reg <= 1'b0;
                    over_flag_reg  <= 1'b0;
                end
                S_DECIDE:
                begin
                    if (op_reg)
                    begin
                        // A drain step repeats the last point with its ratio.
                        e_pos_reg <= last_pos_reg;
                        e_val_reg <= latest_reg;
                    end
                    else if (lower && !restart)
                    begin
                        low_seen_reg <= 1'b1;
                        low_pos_reg  <= pos_in_reg;
                    end
                    else if (!same)
                    begin
                        low_seen_reg <= 1'b0;
                        if (restart || pc_reg == '0)
                        begin
                            start_pos_reg   <= pos_in_reg;
                            last_pos_reg    <= pos_in_reg;
                            last_filter_reg <= {{(FILT_W - RATIO_W){1'b0}}, val_in_reg};
                            pc_reg          <= 16'd1;
                        end
                        else if (pc_reg == 16'd1)
                        begin
                            steps_reg   <= pos_in_reg - start_pos_reg;
                            div_idx_reg <= '0;
                        end
                        else
                        begin
                            e_pos_reg <= pos_in_reg;
                            e_val_reg <= val_in_reg;
                        end
                    end
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        div_idx_reg <= div_idx_reg + 2'd1;
                        if (div_idx_reg == 2'd0)
                        begin
                            q0_reg <= div_quo;
                        end
                        else if (div_idx_reg == 2'd1)
                        begin
                            q1_reg <= div_quo;
                        end
                        else
                        begin
                            tap_reg[TAP_Q12C] <= q0_reg;
                            tap_reg[TAP_Q12L] <= {q0_reg[TAP_W-2:0], 1'b0};
                            tap_reg[TAP_Q11R] <= q1_reg - div_quo;
                            tap_reg[TAP_Q11C] <= q1_reg;
                            tap_reg[TAP_Q11L] <= q1_reg + div_quo;
                            best_reg          <= '0;
                            pc_reg            <= '0;
                            // The first point goes in before this one.
                            e_pos_reg         <= start_pos_reg;
                            e_val_reg         <= last_filter_reg[RATIO_W-1:0];
                            pend_reg          <= 1'b1;
                        end
                    end
                end
                S_ENTER:
                begin
                    if (over_hit)
                    begin
                        pc_reg        <= '0;
                        over_flag_reg <= 1'b1;
                    end
                    else
                    begin
                        if (pc_reg != '1)
                        begin
                            pc_reg <= pc_reg + 16'd1;
                        end
                        last_pos_reg <= e_pos_reg;
                        head_reg     <= head_inc;
                        latest_reg   <= e_val_reg;
                        acc_reg      <= '0 - {{(FILT_W - RATIO_W){1'b0}}, e_val_reg};
                        tap_idx_reg  <= '0;
                    end
                end
                S_TAP:
                begin
                    // Read for one tap while the previous tap's data is accumulated.
                    if (tap_idx_reg < TAP_DONE)
                    begin
                        live_reg    <= POS_W'(tap_sel) < pc_reg;
                        tap_idx_reg <= tap_idx_reg + 3'd1;
                    end
                    if (tap_idx_reg != '0)
                    begin
                        case (prev_idx)
                            TAP_Q12C: acc_reg <= acc_reg + {r_ext[FILT_W-2:0], 1'b0};
                            TAP_Q12L: acc_reg <= acc_reg - r_ext;
                            TAP_Q11R: acc_reg <= acc_reg - r_x3;
                            TAP_Q11C:
                            begin
                                acc_reg     <= acc_reg + {r_x3[FILT_W-2:0], 1'b0};
                                aligned_reg <= live_reg ? rdata[ENTRY_W-1:RATIO_W] : '0;
                                dr_reg      <= r_ext[RATIO_W-1:0];
                            end
                            TAP_Q11L: acc_reg <= acc_reg - r_x3;
                            default:  ;
                        endcase
                    end
                end
                S_EVAL:
                begin
                    last_filter_reg <= acc_reg;
                    if (peak_take)
                    begin
                        best_reg     <= acc_reg[PEAK_W-1:0];
                        best_pos_reg <= aligned_reg;
                    end
                    if (pend_reg)
                    begin
                        pend_reg  <= 1'b0;
                        e_pos_reg <= pos_in_reg;
                        e_val_reg <= val_in_reg;
                    end
                    else
                    begin
                        ready_flag_reg <= pc_reg > POS_W'(tap_reg[TAP_Q11C]);
                    end
                end
                default: ;
            endcase
        end
    end

    // Result register between the sequencer and the output side.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_user_reg  <= {over_flag_reg, ready_flag_reg};
                out_data_reg  <= {last_pos_reg, start_pos_reg, steps_reg, best_reg,
                                  best_pos_reg,
                                  (pc_reg >= 16'd2) ? dr_reg : {RATIO_W{1'b0}},
                                  last_filter_reg, aligned_reg};
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
